// ===== src/rpt_pkg.sv =====
// shared types and constants for the replication progress tracker
// no dependencies; used by rpt_alu and replication_progress_tracker_core
`default_nettype none

package rpt_pkg;

  localparam int FIELD_BITS = 64;
  localparam int ID_BITS    = 4;

  // item mode codes
  localparam logic [1:0] MODE_RESP  = 2'd0;
  localparam logic [1:0] MODE_FIX   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]            mode;
    logic [ID_BITS-1:0]    peer_id;
    logic                  was_accepted;
    logic [FIELD_BITS-1:0] log_index;
    logic [FIELD_BITS-1:0] window_min;
    logic [FIELD_BITS-1:0] window_max;
  } rpt_req_t;

  typedef struct packed {
    logic                  changed;
    logic [FIELD_BITS-1:0] probe_index;
    logic [FIELD_BITS-1:0] catchup_index;
  } rpt_rsp_t;

  // shared adder control: subtract is inv_b with cin set
  typedef struct packed {
    logic inv_b;
    logic cin;
  } alu_ctl_t;

endpackage

`default_nettype wire

// ===== src/replication_progress_tracker_core.sv =====
// replication progress tracker: a response steps through the R_DEC, R_CMP and R_UPD states,
// a query through the Q_* states, a fix walks the slots in F_CLAMP and an unused mode finishes from idle;
// a new item is taken in the cycle the previous strobe is shown. the sequence is set by
// the one shared adder stepping through the compares
// and increments, and for a fix by one table read-modify-write per slot.
// reset (rst, synchronous) clears both tables through per-entry valid bits; results cannot stall
`default_nettype none

module replication_progress_tracker_core #(
  parameter int FOLLOWER_SLOTS = 16,
  parameter int INDEX_BITS     = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rpt_pkg::rpt_req_t req,
  output logic              done,
  output rpt_pkg::rpt_rsp_t rsp
);
  import rpt_pkg::*;

  // adder is one bit wider than an index so compares and +1 keep their carry
  localparam int W         = INDEX_BITS + 1;
  localparam int SLOT_BITS = (FOLLOWER_SLOTS > 1) ? $clog2(FOLLOWER_SLOTS) : 1;
  localparam int ID_EXT    = (SLOT_BITS > ID_BITS) ? SLOT_BITS : ID_BITS;
  localparam int CMP_BITS  = ID_EXT + 1;

  // sequencer: response R_*, query Q_*, fix walks the slots in F_CLAMP
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_R_DEC  = 14'b00000000000010,
    S_R_CMP  = 14'b00000000000100,
    S_R_UPD  = 14'b00000000001000,
    S_Q_LOA  = 14'b00000000010000,
    S_Q_LOR  = 14'b00000000100000,
    S_Q_INC  = 14'b00000001000000,
    S_Q_RLE  = 14'b00000010000000,
    S_Q_SUM  = 14'b00000100000000,
    S_Q_MID  = 14'b00001000000000,
    S_Q_HI1  = 14'b00010000000000,
    S_Q_AC1  = 14'b00100000000000,
    S_Q_FIN  = 14'b01000000000000,
    S_F_CLAMP = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  logic accept;
  logic finish;

  // captured item
  logic                  was_acc;
  logic                  in_rng;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] lo;
  logic [INDEX_BITS-1:0] hi;
  logic [SLOT_BITS-1:0]  addr;
  logic [SLOT_BITS-1:0]  ptr;
  logic                  last_slot;

  // follower id decode
  logic [ID_EXT-1:0]    id_ext;
  logic [SLOT_BITS-1:0] id_addr;
  logic                 id_in_rng;

  // tables: memories plus valid bits, an invalid entry reads as zero (absent)
  logic [INDEX_BITS-1:0]     acc_mem [FOLLOWER_SLOTS];
  logic [INDEX_BITS-1:0]     rej_mem [FOLLOWER_SLOTS];
  logic [FOLLOWER_SLOTS-1:0] acc_vld;
  logic [FOLLOWER_SLOTS-1:0] rej_vld;

  logic                  rd_en;
  logic                  rd_hit;
  logic [SLOT_BITS-1:0]  rd_addr;
  logic [INDEX_BITS-1:0] rd_acc;
  logic [INDEX_BITS-1:0] rd_rej;
  logic                  rd_acc_v;
  logic                  rd_rej_v;
  logic [INDEX_BITS-1:0] acc_cur;
  logic [INDEX_BITS-1:0] rej_cur;

  logic                  acc_we;
  logic                  rej_we;
  logic [SLOT_BITS-1:0]  wr_addr;
  logic [INDEX_BITS-1:0] acc_wdata;

  // shared unit
  logic [W-1:0] alu_a;
  logic [W-1:0] alu_b;
  alu_ctl_t     alu_ctl;
  logic [W-1:0] alu_sum;
  logic         alu_cout;

  // per-item partial results
  logic [INDEX_BITS-1:0] nv;
  logic                  acc_ge_rej;
  logic                  lo_ge_acc;
  logic                  lo_ge_rej;
  logic                  rej_le;
  logic [W-1:0]          t;
  logic [W-1:0]          s;
  logic [INDEX_BITS-1:0] mid1;
  logic [INDEX_BITS-1:0] hi1;
  logic [INDEX_BITS-1:0] acc1;

  logic [INDEX_BITS-1:0] prev;
  logic                  rej_ok;
  logic [INDEX_BITS-1:0] a_sel;
  logic [INDEX_BITS-1:0] probe_fin;
  logic [INDEX_BITS-1:0] catch_fin;
  rpt_rsp_t              rsp_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign id_ext    = ID_EXT'(req.peer_id);
  assign id_addr   = id_ext[SLOT_BITS-1:0];
  assign id_in_rng = CMP_BITS'(req.peer_id) < CMP_BITS'(FOLLOWER_SLOTS);
  assign last_slot = (ptr == SLOT_BITS'(FOLLOWER_SLOTS - 1));

  // entry values as seen by this item (out-of-range ids read as absent)
  assign acc_cur = rd_acc_v ? rd_acc : '0;
  assign rej_cur = rd_rej_v ? rd_rej : '0;

  // stored rejected index counts only while above the accepted one
  assign prev  = (rej_cur != '0 && !acc_ge_rej) ? rej_cur : '0;
  // larger of accepted index and window low end
  assign a_sel = lo_ge_acc ? lo : acc_cur;

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.mode)
            MODE_RESP:  state_next = S_R_DEC;
            MODE_FIX:   state_next = S_F_CLAMP;
            MODE_QUERY: state_next = S_Q_LOA;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_R_DEC:   state_next = S_R_CMP;
      S_R_CMP:   state_next = S_R_UPD;
      S_R_UPD:   state_next = S_IDLE;
      S_Q_LOA:   state_next = S_Q_LOR;
      S_Q_LOR:   state_next = S_Q_INC;
      S_Q_INC:   state_next = S_Q_RLE;
      S_Q_RLE:   state_next = S_Q_SUM;
      S_Q_SUM:   state_next = S_Q_MID;
      S_Q_MID:   state_next = S_Q_HI1;
      S_Q_HI1:   state_next = S_Q_AC1;
      S_Q_AC1:   state_next = S_Q_FIN;
      S_Q_FIN:   state_next = S_IDLE;
      S_F_CLAMP: state_next = last_slot ? S_IDLE : S_F_CLAMP;
      default:   state_next = S_IDLE;
    endcase
  end

  // unused mode finishes straight from idle with an all-zero result
  assign finish = (state == S_R_UPD) || (state == S_Q_FIN) ||
                  ((state == S_F_CLAMP) && last_slot) ||
                  (accept && req.mode != MODE_RESP && req.mode != MODE_FIX &&
                   req.mode != MODE_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      ptr   <= '0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (accept) begin
        ptr <= '0;
      end else if (state == S_F_CLAMP) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // item capture, indices taken modulo 2^INDEX_BITS
  always_ff @(posedge clk) begin
    if (accept) begin
      was_acc <= req.was_accepted;
      in_rng  <= id_in_rng;
      idx     <= req.log_index[INDEX_BITS-1:0];
      lo      <= req.window_min[INDEX_BITS-1:0];
      hi      <= req.window_max[INDEX_BITS-1:0];
      addr    <= id_addr;
    end
  end

  // ---------------------------------------------------------------
  // table access: one read and one write port per table
  // ---------------------------------------------------------------
  always_comb begin
    rd_en   = 1'b0;
    rd_hit  = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        rd_en   = accept;
        rd_hit  = (req.mode == MODE_FIX) || id_in_rng;
        rd_addr = (req.mode == MODE_FIX) ? '0 : id_addr;
      end
      S_F_CLAMP: begin
        // fetch the next slot while the current one is clamped
        rd_en   = !last_slot;
        rd_hit  = 1'b1;
        rd_addr = ptr + 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    acc_we    = 1'b0;
    rej_we    = 1'b0;
    wr_addr   = addr;
    acc_wdata = nv;
    rej_ok    = !(prev != '0 && alu_cout) && (nv != prev);
    case (state)
      S_R_UPD: begin
        acc_we = in_rng && was_acc && !alu_cout;
        rej_we = in_rng && !was_acc && rej_ok;
      end
      S_F_CLAMP: begin
        wr_addr   = ptr;
        acc_wdata = idx;
        acc_we    = !alu_cout;
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_acc <= acc_mem[rd_addr];
      rd_rej <= rej_mem[rd_addr];
    end
    if (acc_we) begin
      acc_mem[wr_addr] <= acc_wdata;
    end
    if (rej_we) begin
      rej_mem[wr_addr] <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld  <= '0;
      rej_vld  <= '0;
      rd_acc_v <= 1'b0;
      rd_rej_v <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_acc_v <= rd_hit && acc_vld[rd_addr];
        rd_rej_v <= rd_hit && rej_vld[rd_addr];
      end
      if (acc_we) begin
        acc_vld[wr_addr] <= 1'b1;
      end
      if (rej_we) begin
        rej_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // shared adder operand selection, one operation per state
  // ---------------------------------------------------------------
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_ctl = '{inv_b: 1'b0, cin: 1'b0};
    case (state)
      S_R_DEC: begin
        // log_index - 1 by adding all ones
        alu_a   = W'(idx);
        alu_ctl = '{inv_b: 1'b1, cin: 1'b0};
      end
      S_R_CMP: begin
        alu_a   = W'(acc_cur);
        alu_b   = W'(rej_cur);
        alu_ctl = '{inv_b: 1'b1, cin: 1'b1};
      end
      S_R_UPD: begin
        // accepted: acc >= nv blocks; rejected: nv >= prev blocks
        alu_a   = was_acc ? W'(acc_cur) : W'(nv);
        alu_b   = was_acc ? W'(nv) : W'(prev);
        alu_ctl = '{inv_b: 1'b1, cin: 1'b1};
      end
      S_Q_LOA: begin
        alu_a   = W'(lo);
        alu_b   = W'(acc_cur);
        alu_ctl = '{inv_b: 1'b1, cin: 1'b1};
      end
      S_Q_LOR: begin
        alu_a   = W'(lo);
        alu_b   = W'(rej_cur);
        alu_ctl = '{inv_b: 1'b1, cin: 1'b1};
      end
      S_Q_INC: begin
        alu_a   = W'(a_sel);
        alu_ctl = '{inv_b: 1'b0, cin: 1'b1};
      end
      S_Q_RLE: begin
        // exact rej <= a + 1
        alu_a   = t;
        alu_b   = W'(rej_cur);
        alu_ctl = '{inv_b: 1'b1, cin: 1'b1};
      end
      S_Q_SUM: begin
        alu_a = W'(a_sel);
        alu_b = W'(rej_cur);
      end
      S_Q_MID: begin
        // floor of the carried sum over two, plus one
        alu_a   = {1'b0, s[W-1:1]};
        alu_ctl = '{inv_b: 1'b0, cin: 1'b1};
      end
      S_Q_HI1: begin
        alu_a   = W'(hi);
        alu_ctl = '{inv_b: 1'b0, cin: 1'b1};
      end
      S_Q_AC1: begin
        alu_a   = W'(acc_cur);
        alu_ctl = '{inv_b: 1'b0, cin: 1'b1};
      end
      S_F_CLAMP: begin
        // limit >= entry keeps the entry
        alu_a   = W'(idx);
        alu_b   = W'(acc_cur);
        alu_ctl = '{inv_b: 1'b1, cin: 1'b1};
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  rpt_alu #(
    .W (W)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ctl  (alu_ctl),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  always_ff @(posedge clk) begin
    case (state)
      S_R_DEC: nv         <= alu_sum[INDEX_BITS-1:0];
      S_R_CMP: acc_ge_rej <= alu_cout;
      S_Q_LOA: lo_ge_acc  <= alu_cout;
      S_Q_LOR: lo_ge_rej  <= alu_cout;
      S_Q_INC: t          <= alu_sum;
      S_Q_RLE: rej_le     <= alu_cout;
      S_Q_SUM: s          <= alu_sum;
      S_Q_MID: mid1       <= alu_sum[INDEX_BITS-1:0];
      S_Q_HI1: hi1        <= alu_sum[INDEX_BITS-1:0];
      S_Q_AC1: acc1       <= alu_sum[INDEX_BITS-1:0];
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------
  // query result from the collected flags
  // ---------------------------------------------------------------
  always_comb begin
    // probe: binary search point between known-good and known-bad
    if (lo == '0 || lo == hi) begin
      probe_fin = '0;
    end else if (acc_cur == '0 && rej_cur == '0) begin
      probe_fin = hi1;
    end else if (rej_cur == '0 || rej_le) begin
      probe_fin = '0;
    end else begin
      probe_fin = mid1;
    end

    // catch-up: only when no probe is pending
    if (lo == '0 || probe_fin != '0) begin
      catch_fin = '0;
    end else if (acc_cur == '0) begin
      if (rej_cur != '0 && lo_ge_rej) begin
        catch_fin = (lo == INDEX_BITS'(1)) ? INDEX_BITS'(1) : '0;
      end else begin
        catch_fin = lo;
      end
    end else if ((lo_ge_acc && lo != acc_cur) || acc_cur == hi) begin
      catch_fin = '0;
    end else begin
      catch_fin = acc1;
    end
  end

  always_comb begin
    rsp_next = '0;
    case (state)
      S_R_UPD: begin
        rsp_next.changed = acc_we || rej_we;
      end
      S_Q_FIN: begin
        rsp_next.probe_index   = FIELD_BITS'(probe_fin);
        rsp_next.catchup_index = FIELD_BITS'(catch_fin);
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp <= rsp_next;
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.mode == MODE_RESP || req.mode == MODE_FIX ||
                        req.mode == MODE_QUERY)) |=> busy)
    else $error("busy not raised after a multi-cycle item");

  a_done_on_finish: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("item finished without a result strobe");

  a_changed_resp: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.changed) |-> $past(state == S_R_UPD))
    else $error("changed flag on a non-response item");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (acc_we || rej_we) |-> busy)
    else $error("table written while idle");

endmodule

`default_nettype wire

// ===== src/rpt_alu.sv =====
// shared add / subtract / compare unit of the tracker sequencer
// depends on rpt_pkg for the control struct
`default_nettype none

module rpt_alu #(
  parameter int W = 65
) (
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  input  rpt_pkg::alu_ctl_t ctl,
  output logic [W-1:0]      sum,
  output logic              cout
);
  import rpt_pkg::*;

  logic [W-1:0] b_op;

  assign b_op = ctl.inv_b ? ~b : b;
  // on subtract, cout set means a >= b
  assign {cout, sum} = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, ctl.cin};

endmodule

`default_nettype wire

// ===== tb/tb_replication_progress_tracker_core.sv =====
`timescale 1ns / 1ps
// testbench for replication_progress_tracker_core: directed and random items
// checked against an in-bench copy of the follower tables; depends on rpt_pkg

module tb_replication_progress_tracker_core;
  import rpt_pkg::*;

  localparam int          SLOTS        = 16;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [63:0] ALL_ONES     = '1;
  localparam int          RANDOM_ITEMS = 1050;
  // slowest item is a fix, which walks every table slot, plus a sender gap
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_REPORTS  = 10;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  rpt_req_t req;
  logic     done;
  rpt_rsp_t rsp;

  replication_progress_tracker_core #(
    .FOLLOWER_SLOTS(SLOTS),
    .INDEX_BITS    (64)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the follower tables, 0 means no entry
  logic [63:0] accepted_idx [SLOTS];
  logic [63:0] rejected_idx [SLOTS];

  rpt_req_t item_backlog[$];      // items not yet offered to the block
  rpt_rsp_t pending_outcomes[$];  // outcomes of accepted items, oldest first
  rpt_rsp_t oldest_outcome;

  logic item_taken = 1'b0;        // set at the edge that accepts an item
  int   cycle_count = 0;
  int   mismatch_count = 0;
  int   gap_left = 0;
  int   burst_left = 8;

  // ---------------------------------------------------------------------------
  // tracker model
  // ---------------------------------------------------------------------------

  // floor((a + b) / 2) + 1 with the carry kept
  function automatic logic [63:0] midpoint_up(logic [63:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64:1] + 64'd1;
  endfunction

  // r <= m + 1 without wrapping m + 1
  function automatic logic at_most_next(logic [63:0] r, logic [63:0] m);
    return {1'b0, r} <= ({1'b0, m} + 65'd1);
  endfunction

  // binary search probe; uses the stored rejected index as is
  function automatic logic [63:0] probe_for(logic [3:0] id, logic [63:0] lo,
                                            logic [63:0] hi);
    logic [63:0] acc;
    logic [63:0] rej;
    logic [63:0] floor_idx;
    acc = accepted_idx[id];
    rej = rejected_idx[id];
    if (lo == '0 || lo == hi) return '0;
    if (acc == '0) begin
      if (rej == '0) return hi + 64'd1;  // wraps when hi is all ones
      if (at_most_next(rej, lo)) return '0;
      return midpoint_up(lo, rej);
    end
    floor_idx = (acc > lo) ? acc : lo;
    if (rej == '0 || at_most_next(rej, floor_idx)) return '0;
    return midpoint_up(floor_idx, rej);
  endfunction

  // catch-up index, only once no probe is needed
  function automatic logic [63:0] catchup_for(logic [3:0] id, logic [63:0] lo,
                                              logic [63:0] hi);
    logic [63:0] acc;
    logic [63:0] rej;
    acc = accepted_idx[id];
    rej = rejected_idx[id];
    if (lo == '0) return '0;
    if (probe_for(id, lo, hi) != '0) return '0;
    if (acc == '0) begin
      if (rej != '0 && lo >= rej) return (lo == 64'd1) ? 64'd1 : 64'd0;
      return lo;
    end
    if (acc < lo || acc == hi) return '0;
    return acc + 64'd1;  // wraps at all ones
  endfunction

  // applies one item to the tables and returns the outcome the block owes
  function automatic rpt_rsp_t progress_outcome(rpt_req_t item);
    rpt_rsp_t    outcome;
    logic [63:0] next_val;
    logic [63:0] live_rej;
    logic [3:0]  id;
    outcome  = '0;
    id       = item.peer_id;
    next_val = item.log_index - 64'd1;  // next index zero wraps to all ones
    case (item.mode)
      MODE_RESP: begin
        if (item.was_accepted) begin
          if (next_val > accepted_idx[id]) begin
            accepted_idx[id] = next_val;
            outcome.changed  = 1'b1;
          end
        end else begin
          // a rejected index only counts while above the accepted one
          live_rej = (rejected_idx[id] != '0 && accepted_idx[id] < rejected_idx[id]) ?
                     rejected_idx[id] : '0;
          if (!(live_rej != '0 && next_val >= live_rej) && next_val != live_rej) begin
            rejected_idx[id] = next_val;
            outcome.changed  = 1'b1;
          end
        end
      end
      MODE_FIX: begin
        for (int s = 0; s < SLOTS; s++)
          if (accepted_idx[s] > item.log_index) accepted_idx[s] = item.log_index;
      end
      MODE_QUERY: begin
        outcome.probe_index   = probe_for(id, item.window_min, item.window_max);
        outcome.catchup_index = catchup_for(id, item.window_min, item.window_max);
      end
      default: begin
        // unused mode: tables untouched, all-zero result
      end
    endcase
    return outcome;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_item(logic [1:0] mode, logic [3:0] id, logic ok,
                            logic [63:0] idx, logic [63:0] lo, logic [63:0] hi);
    rpt_req_t item;
    item.mode         = mode;
    item.peer_id      = id;
    item.was_accepted = ok;
    item.log_index    = idx;
    item.window_min   = lo;
    item.window_max   = hi;
    item_backlog.push_back(item);
  endtask

  // indices mostly close together so entries collide, some near the top
  function automatic logic [63:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return 64'($urandom_range(40));
    if (roll < 80) return ALL_ONES - 64'($urandom_range(40));
    if (roll < 88) return 64'($urandom_range(4000));
    return {$urandom, $urandom};
  endfunction

  task automatic load_random_items();
    int unsigned roll;
    logic [1:0]  mode;
    logic [3:0]  id;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] swap;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(99);
      if (roll < 55)      mode = MODE_RESP;
      else if (roll < 60) mode = MODE_FIX;
      else if (roll < 63) mode = MODE_UNUSED;
      else                mode = MODE_QUERY;
      // a few followers take most of the traffic so histories build up
      id = ($urandom_range(99) < 80) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      lo = pick_index();
      hi = pick_index();
      if ($urandom_range(99) < 85 && lo > hi) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      case (mode)
        MODE_RESP:
          queue_item(mode, id, 1'($urandom), pick_index(), {$urandom, $urandom},
                     {$urandom, $urandom});
        MODE_QUERY:
          queue_item(mode, id, 1'($urandom), {$urandom, $urandom}, lo, hi);
        MODE_FIX:
          queue_item(mode, id, 1'($urandom), pick_index(), {$urandom, $urandom},
                     {$urandom, $urandom});
        default:
          queue_item(mode, id, 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom});
      endcase
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      accepted_idx[s] = '0;
      rejected_idx[s] = '0;
    end

    // directed part
    queue_item(MODE_QUERY, 4'd1,  1'b0, '0, '0, '0);                // empty log
    queue_item(MODE_QUERY, 4'd1,  1'b0, '0, 64'd5, 64'd10);         // no entries, probe max+1
    queue_item(MODE_QUERY, 4'd1,  1'b0, '0, 64'd1, ALL_ONES);       // max+1 wraps to zero
    queue_item(MODE_QUERY, 4'd1,  1'b0, '0, 64'd7, 64'd7);          // min equals max
    queue_item(MODE_RESP,  4'd1,  1'b1, 64'd6, '0, '0);             // accepted up to 5
    queue_item(MODE_RESP,  4'd1,  1'b0, 64'd9, '0, '0);             // rejected at 8
    queue_item(MODE_QUERY, 4'd1,  1'b0, '0, 64'd3, 64'd20);         // midpoint probe
    queue_item(MODE_RESP,  4'd1,  1'b1, 64'd1, '0, '0);             // next index one
    queue_item(MODE_RESP,  4'd2,  1'b1, 64'd0, '0, '0);             // next index zero wraps
    queue_item(MODE_QUERY, 4'd2,  1'b0, '0, 64'd1, 64'd5);          // catch-up wraps
    queue_item(MODE_RESP,  4'd0,  1'b1, 64'd12, ALL_ONES, ALL_ONES); // follower zero
    queue_item(MODE_RESP,  4'd15, 1'b0, 64'd0, '0, '0);             // rejected all ones
    queue_item(MODE_QUERY, 4'd15, 1'b1, ALL_ONES, ALL_ONES - 64'd9, ALL_ONES); // carry
    queue_item(MODE_QUERY, 4'd0,  1'b0, '0, 64'd20, 64'd3);         // min above max
    queue_item(MODE_RESP,  4'd3,  1'b0, ALL_ONES, '0, '0);
    queue_item(MODE_RESP,  4'd3,  1'b1, ALL_ONES, '0, '0);          // hides the rejection
    queue_item(MODE_QUERY, 4'd3,  1'b0, '0, ALL_ONES - 64'd20, ALL_ONES - 64'd1);
    queue_item(MODE_FIX,   4'd0,  1'b0, 64'd3, '0, '0);             // clamp
    queue_item(MODE_QUERY, 4'd1,  1'b0, '0, 64'd2, 64'd30);
    queue_item(MODE_FIX,   4'd0,  1'b0, 64'd0, '0, '0);             // clamp to zero erases
    queue_item(MODE_FIX,   4'd15, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES); // no effect
    queue_item(MODE_UNUSED, 4'd15, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
    queue_item(MODE_RESP,  4'd4,  1'b0, 64'd1, '0, '0);             // rejected at zero, none
    queue_item(MODE_RESP,  4'd1,  1'b0, 64'd1, '0, '0);             // lowers a live rejection
    queue_item(MODE_QUERY, 4'd1,  1'b1, ALL_ONES, 64'd2, 64'd9);

    load_random_items();

    // reset held, then released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every item offered and taken, then every outcome seen
    while (item_backlog.size() > 0 || start) @(posedge clk);
    while (pending_outcomes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of items with random gaps, changes on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // block still busy, keep the item up
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left = gap_left - 1;
    end else if (item_backlog.size() > 0) begin
      req   <= item_backlog.pop_front();
      start <= 1'b1;
      if (burst_left > 1) begin
        burst_left = burst_left - 1;
      end else begin
        // next burst; a zero gap now and then gives long unbroken runs
        burst_left = $urandom_range(40, 1);
        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      end
    end else begin
      start <= 1'b0;
    end
    item_taken = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each strobed result and records accepted items
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %0s", cycle_count, msg);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result strobe with no item outstanding");
        end else begin
          oldest_outcome = pending_outcomes.pop_front();
          if (rsp.changed !== oldest_outcome.changed)
            report_mismatch($sformatf("changed expected %0b got %0b",
                                      oldest_outcome.changed, rsp.changed));
          if (rsp.probe_index !== oldest_outcome.probe_index)
            report_mismatch($sformatf("probe_index expected %h got %h",
                                      oldest_outcome.probe_index, rsp.probe_index));
          if (rsp.catchup_index !== oldest_outcome.catchup_index)
            report_mismatch($sformatf("catchup_index expected %h got %h",
                                      oldest_outcome.catchup_index, rsp.catchup_index));
        end
      end
      // the same edge may take the next item; its outcome queues behind
      if (start && !busy) begin
        pending_outcomes.push_back(progress_outcome(req));
        item_taken = 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
